@@ rtl/sacts_pkg.sv @@
// Shared constants, codes and types of the set-associative tag store.
package sacts_pkg;

  localparam int ADDR_W         = 32;
  localparam int AGE_W          = 8;
  localparam int WAY_OUT_W      = 2;
  localparam int DEF_WAYS       = 4;
  localparam int DEF_LINES      = 256;
  localparam int DEF_LINE_BYTES = 32;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  typedef enum logic {
    OP_LOOKUP   = 1'b0,
    OP_ALLOCATE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 writeback_valid;
    logic [ADDR_W-1:0]    writeback_address;
  } result_t;

endpackage

@@ rtl/sacts_set_update.sv @@
// Lookup / allocate decision and new row contents for one set.
module sacts_set_update #(
  parameter int WAYS      = sacts_pkg::DEF_WAYS,
  parameter int WAY_W     = 2,
  parameter int IDX_W     = 6,
  parameter int OFF_BITS  = 5,
  parameter int TAG_BITS  = 21
) (
  input  sacts_pkg::opcode_t                         opcode,
  input  logic                                       mark_dirty,
  input  logic [IDX_W-1:0]                           set_idx,
  input  logic [TAG_BITS-1:0]                        tag,
  input  logic [WAYS-1:0]                            cur_valid,
  input  logic [WAYS-1:0]                            cur_dirty,
  input  logic [WAYS-1:0][sacts_pkg::AGE_W-1:0]      cur_age,
  input  logic [WAYS-1:0][TAG_BITS-1:0]              cur_tag,
  output logic [WAYS-1:0]                            new_valid,
  output logic [WAYS-1:0]                            new_dirty,
  output logic [WAYS-1:0][sacts_pkg::AGE_W-1:0]      new_age,
  output logic [WAYS-1:0][TAG_BITS-1:0]              new_tag,
  output sacts_pkg::result_t                         result
);

  localparam int TAG_SHIFT = sacts_pkg::ADDR_W - TAG_BITS;

  logic                          hit_found;
  logic [WAY_W-1:0]              hit_way;
  logic                          inv_found;
  logic [WAY_W-1:0]              inv_way;
  logic [WAY_W-1:0]              victim;
  logic [sacts_pkg::AGE_W-1:0]   oldest;
  logic [WAY_W-1:0]              sel_way;
  logic [WAY_W+1:0]              sel_way_ext;
  logic [sacts_pkg::ADDR_W-1:0]  victim_addr;

  // Scan the set: hit detection, first invalid way, first oldest way.
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    victim    = '0;
    oldest    = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (cur_valid[w] && (cur_tag[w] == tag)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (!inv_found && !cur_valid[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
      if (cur_age[w] > oldest) begin
        oldest = cur_age[w];
        victim = WAY_W'(w);
      end
    end
  end

  assign sel_way     = inv_found ? inv_way : victim;
  assign victim_addr = {cur_tag[victim], {TAG_SHIFT{1'b0}}}
                     | (sacts_pkg::ADDR_W'(set_idx) << OFF_BITS);

  always_comb begin
    new_valid = cur_valid;
    new_dirty = cur_dirty;
    new_age   = cur_age;
    new_tag   = cur_tag;
    result    = '0;
    unique case (opcode)
      sacts_pkg::OP_LOOKUP: begin
        for (int w = 0; w < WAYS; w++) begin
          if (cur_valid[w]) begin
            if (cur_tag[w] == tag) begin
              new_age[w] = '0;
            end else if (cur_age[w] != sacts_pkg::AGE_MAX) begin
              new_age[w] = cur_age[w] + 1'b1;
            end
          end
          if (hit_found && mark_dirty && (WAY_W'(w) == hit_way)) begin
            new_dirty[w] = 1'b1;
          end
        end
        sel_way_ext = {2'b00, hit_way};
        result.hit  = hit_found;
        result.way  = hit_found ? sel_way_ext[1:0] : '0;
      end
      sacts_pkg::OP_ALLOCATE: begin
        for (int w = 0; w < WAYS; w++) begin
          if (WAY_W'(w) == sel_way) begin
            new_valid[w] = 1'b1;
            new_dirty[w] = mark_dirty;
            new_age[w]   = '0;
            new_tag[w]   = tag;
          end
        end
        sel_way_ext = {2'b00, sel_way};
        result.hit  = 1'b1;
        result.way  = sel_way_ext[1:0];
        if (!inv_found && cur_dirty[victim]) begin
          result.writeback_valid   = 1'b1;
          result.writeback_address = victim_addr;
        end
      end
      default: begin
        sel_way_ext = '0;
      end
    endcase
  end

endmodule

@@ rtl/set_assoc_cache_tag_store_lru.sv @@
// Top level: set-associative tag store with age-counter LRU in one set-wide memory.
// An accepted request has its set row read into a register, then its response is loaded
// into the output register once the previous response is no longer stalled downstream.
// A new request is not taken until the read then write-back of the set row is through.
// A finished response waits in its register while the next request is taken and read.
// Reset: a clearing pass writes every set row to zero, one row a cycle (2**set bits rows,
// at least 2; 64 at default geometry); no request is accepted until it ends.
module set_assoc_cache_tag_store_lru #(
  parameter int WAYS       = sacts_pkg::DEF_WAYS,
  parameter int LINES      = sacts_pkg::DEF_LINES,
  parameter int LINE_BYTES = sacts_pkg::DEF_LINE_BYTES
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // request channel
  input  logic                                      req_valid,
  output logic                                      req_stall,
  input  logic                                      opcode,
  input  logic [sacts_pkg::ADDR_W-1:0]              address,
  input  logic                                      mark_dirty,
  // response channel
  output logic                                      rsp_valid,
  input  logic                                      rsp_stall,
  output logic                                      hit,
  output logic [sacts_pkg::WAY_OUT_W-1:0]           way,
  output logic                                      writeback_valid,
  output logic [sacts_pkg::ADDR_W-1:0]              writeback_address
);

  // Geometry: floor of log2 for offset and set widths, at least one set.
  localparam int SETS      = (LINES / WAYS) > 0 ? (LINES / WAYS) : 1;
  localparam int OFF_BITS  = $clog2(LINE_BYTES + 1) - 1;
  localparam int SET_BITS  = $clog2(SETS + 1) - 1;
  localparam int TAG_SHIFT = OFF_BITS + SET_BITS;
  localparam int TAG_BITS  = sacts_pkg::ADDR_W - TAG_SHIFT;
  localparam int IDX_W     = SET_BITS > 0 ? SET_BITS : 1;
  localparam int ROWS      = 1 << IDX_W;
  localparam int WAY_W     = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int ROW_W     = WAYS * (2 + sacts_pkg::AGE_W + TAG_BITS);
  localparam logic [IDX_W-1:0] SET_MASK = IDX_W'((64'd1 << SET_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state, state_next;
  logic [IDX_W-1:0] clr_idx;

  // Request held for the update cycle.
  sacts_pkg::opcode_t  req_op;
  logic                req_mark;
  logic [IDX_W-1:0]    req_set;
  logic [TAG_BITS-1:0] req_tag;

  logic                          accept;
  logic                          slot_free;
  logic                          commit;
  logic [sacts_pkg::ADDR_W-1:0]  addr_shifted;
  logic [IDX_W-1:0]              in_set;

  // Set row memory: {valid, dirty, age, tag} for every way of one set.
  logic [ROW_W-1:0] row_mem [ROWS];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic [IDX_W-1:0] wr_idx;
  logic             mem_we;

  logic [WAYS-1:0]                        cur_valid, new_valid;
  logic [WAYS-1:0]                        cur_dirty, new_dirty;
  logic [WAYS-1:0][sacts_pkg::AGE_W-1:0]  cur_age, new_age;
  logic [WAYS-1:0][TAG_BITS-1:0]          cur_tag, new_tag;
  sacts_pkg::result_t                     upd_result;

  assign addr_shifted = address >> OFF_BITS;
  assign in_set       = addr_shifted[IDX_W-1:0] & SET_MASK;

  // Take a request only when idle; one transaction is in the set update at a time.
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // The response register is free when empty or being drained this cycle.
  assign slot_free = !rsp_valid || !rsp_stall;
  assign commit    = (state == ST_UPDATE) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == {IDX_W{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_UPDATE;
      ST_UPDATE: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Capture the request fields with the read of its set.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= sacts_pkg::opcode_t'(opcode);
      req_mark <= mark_dirty;
      req_set  <= in_set;
      req_tag  <= address[sacts_pkg::ADDR_W-1:TAG_SHIFT];
    end
  end

  // Write a zero row during the clearing pass, the updated row on commit.
  assign mem_we = (state == ST_CLEAR) || commit;
  assign wr_idx = (state == ST_CLEAR) ? clr_idx : req_set;
  assign wr_row = (state == ST_CLEAR) ? '0 : {new_valid, new_dirty, new_age, new_tag};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[wr_idx] <= wr_row;
    end
    if (accept) begin
      rd_row <= row_mem[in_set];
    end
  end

  assign {cur_valid, cur_dirty, cur_age, cur_tag} = rd_row;

  sacts_set_update #(
    .WAYS     (WAYS),
    .WAY_W    (WAY_W),
    .IDX_W    (IDX_W),
    .OFF_BITS (OFF_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_update (
    .opcode     (req_op),
    .mark_dirty (req_mark),
    .set_idx    (req_set),
    .tag        (req_tag),
    .cur_valid  (cur_valid),
    .cur_dirty  (cur_dirty),
    .cur_age    (cur_age),
    .cur_tag    (cur_tag),
    .new_valid  (new_valid),
    .new_dirty  (new_dirty),
    .new_age    (new_age),
    .new_tag    (new_tag),
    .result     (upd_result)
  );

  // Response register: load on commit, drop once taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit               <= upd_result.hit;
      way               <= upd_result.way;
      writeback_valid   <= upd_result.writeback_valid;
      writeback_address <= upd_result.writeback_address;
    end
  end

endmodule
